### src/mte_pkg.sv
// Shared types and constants for the mutex table engine.
package mte_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_LOCK   = 2'd2;
  localparam logic [1:0] CMD_UNLOCK = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mutex_ident;
    logic [7:0]  requester;
  } mte_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] new_ident;
  } mte_out_t;

  // One table entry as seen by the sequencer.
  typedef struct packed {
    logic        used;
    logic        locked;
    logic [15:0] ident;
    logic [7:0]  owner;
  } mte_entry_t;

  // Write request into the table.
  typedef struct packed {
    logic       en;
    mte_entry_t data;
  } mte_wr_t;

endpackage

### src/mte_table.sv
// Mutex entry storage: one indexed read and one write at the same index.
module mte_table (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [mte_pkg::IDX_W-1:0] idx,
  input  mte_pkg::mte_wr_t        wr,
  output mte_pkg::mte_entry_t     rd
);
  import mte_pkg::*;

  logic        used   [ENTRIES];
  logic        locked [ENTRIES];
  logic [15:0] ident  [ENTRIES];
  logic [7:0]  owner  [ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] <= 1'b0;
      end
    end else if (wr.en) begin
      used[idx] <= wr.data.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      locked[idx] <= wr.data.locked;
      ident[idx]  <= wr.data.ident;
      owner[idx]  <= wr.data.owner;
    end
  end

  // An unused entry always reads as all zero, which is the cleared state.
  always_comb begin
    rd.used   = used[idx];
    rd.locked = used[idx] ? locked[idx] : 1'b0;
    rd.ident  = used[idx] ? ident[idx]  : 16'd0;
    rd.owner  = used[idx] ? owner[idx]  : 8'd0;
  end

endmodule

### src/mutex_table_engine.sv
// Mutex table engine: allocate, free, lock and unlock over a scanned entry table.
//
// Each command is one request transfer and gives one response transfer. The
// engine scans the table one entry per cycle through a single compare unit,
// stopping at the first match (first unused entry for allocate, first entry
// with a matching identifier otherwise), then updates the entry in an execute
// state that waits until the output register can take the response. The
// request side stalls while a command is in progress; a finished response
// waits in an output register. The table is empty after reset and the
// identifier counter starts at 1.
module mutex_table_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  mte_pkg::mte_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output mte_pkg::mte_out_t rsp
);
  import mte_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]       state;
  logic [IDX_W-1:0] idx;
  logic             hit;
  mte_in_t          cur;
  logic [15:0]      next_ident;
  logic [15:0]      next_ident_next;
  mte_entry_t       ent;
  mte_wr_t          wr;
  logic             match;
  logic             last;
  logic             slot_free;
  mte_out_t         res;

  mte_table u_table (
    .clk (clk),
    .rst (rst),
    .idx (idx),
    .wr  (wr),
    .rd  (ent)
  );

  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign last      = (idx == IDX_W'(ENTRIES - 1));

  // The shared compare: unused for allocate, identifier match otherwise.
  assign match = (cur.cmd == CMD_ALLOC) ? !ent.used : (ent.ident == cur.mutex_ident);

  assign next_ident_next = (next_ident == 16'hFFFF) ? 16'd1 : next_ident + 16'd1;

  always_comb begin
    wr         = '0;
    res.status = ST_FAIL;
    res.new_ident = 16'd0;
    if (state == S_EXEC && hit) begin
      case (cur.cmd)
        CMD_ALLOC: begin
          wr.en         = 1'b1;
          wr.data.used  = 1'b1;
          wr.data.ident = next_ident;
          res.status    = ST_OK;
          res.new_ident = next_ident;
        end
        CMD_FREE: begin
          if (ent.used && !ent.locked && ent.owner == 8'd0) begin
            wr.en      = 1'b1;
            res.status = ST_OK;
          end
        end
        CMD_LOCK: begin
          if (ent.used) begin
            if (ent.locked) begin
              res.status = ST_BUSY;
            end else begin
              wr.en          = 1'b1;
              wr.data        = ent;
              wr.data.locked = 1'b1;
              wr.data.owner  = cur.requester;
              res.status     = ST_OK;
            end
          end
        end
        CMD_UNLOCK: begin
          if (ent.used && ent.locked && ent.owner == cur.requester) begin
            wr.en          = 1'b1;
            wr.data        = ent;
            wr.data.locked = 1'b0;
            wr.data.owner  = 8'd0;
            res.status     = ST_OK;
          end
        end
        default: begin
          res.status = ST_FAIL;
        end
      endcase
    end
    // The update happens only in the cycle the response is loaded.
    if (!slot_free) begin
      wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      hit        <= 1'b0;
      next_ident <= 16'd1;
      rsp_valid  <= 1'b0;
    end else begin
      if (state == S_EXEC && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            idx   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match || last) begin
            hit   <= match;
            state <= S_EXEC;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            state <= S_IDLE;
            if (hit && cur.cmd == CMD_ALLOC) begin
              next_ident <= next_ident_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cur <= req;
    end
    if (state == S_EXEC && slot_free) begin
      rsp <= res;
    end
  end

  a_ident_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_ident != 16'd0)
    else $error("identifier counter reached zero");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_SCAN && idx == '0))
    else $error("accepted transfer did not start a scan at entry zero");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_FAIL || rsp.status == ST_BUSY))
    else $error("response carries an undefined status");

  a_ident_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.new_ident != 16'd0) |-> (rsp.status == ST_OK))
    else $error("identifier returned without success");

endmodule

### bench/tb_mutex_table_engine.sv
// Self-checking testbench for the mutex table engine.
`timescale 1ns / 1ps

module tb_mutex_table_engine;
  import mte_pkg::*;

  typedef struct {
    mte_in_t  cmd;
    logic     typed;
    mte_out_t rsp;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  mte_in_t  req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  mte_out_t rsp;

  // Shadow copy of the mutex table, advanced once per accepted request.
  logic        tbl_used   [ENTRIES];
  logic        tbl_locked [ENTRIES];
  logic [15:0] tbl_ident  [ENTRIES];
  logic [7:0]  tbl_owner  [ENTRIES];
  logic [15:0] ident_ctr;

  mte_out_t expected_rsp[$];
  mte_out_t want;
  dir_row_t directed_rows[$];

  int   cmds_sent  = 0;
  int   rsp_seen   = 0;
  int   mismatches = 0;
  int   full_hits  = 0;
  int   busy_hits  = 0;
  int   ctr_wraps  = 0;
  int   burst_left = 0;
  int   stall_mode = 0;
  int   stall_left = 0;
  int   stall_tick = 0;

  mutex_table_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic mte_in_t cmd_of(logic [1:0] op, logic [15:0] id, logic [7:0] who);
    mte_in_t c;
    c.cmd = op;
    c.mutex_ident = id;
    c.requester = who;
    return c;
  endfunction

  function automatic dir_row_t row(logic [1:0] op, logic [15:0] id, logic [7:0] who,
                                   logic typed, logic [1:0] st, logic [15:0] given);
    dir_row_t r;
    r.cmd = cmd_of(op, id, who);
    r.typed = typed;
    r.rsp.status = st;
    r.rsp.new_ident = given;
    return r;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_locked[i] = 1'b0;
      tbl_ident[i] = '0;
      tbl_owner[i] = '0;
    end
    ident_ctr = 16'd1;
  endfunction

  // Applies one command to the shadow table and returns the response it should give.
  function automatic mte_out_t apply_command(mte_in_t c);
    mte_out_t r;
    int idx;
    r.status = ST_FAIL;
    r.new_ident = '0;
    idx = ENTRIES;
    if (c.cmd == CMD_ALLOC) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!tbl_used[i]) begin
          idx = i;
          break;
        end
      end
      if (idx < ENTRIES) begin
        tbl_used[idx] = 1'b1;
        tbl_locked[idx] = 1'b0;
        tbl_owner[idx] = '0;
        tbl_ident[idx] = ident_ctr;
        r.new_ident = ident_ctr;
        r.status = ST_OK;
        if (ident_ctr == 16'hFFFF) begin
          ident_ctr = 16'd1;
          ctr_wraps++;
        end else begin
          ident_ctr = ident_ctr + 16'd1;
        end
      end else begin
        full_hits++;
      end
    end else begin
      // The lookup ignores the used flag, so identifier zero can land on an empty entry.
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_ident[i] == c.mutex_ident) begin
          idx = i;
          break;
        end
      end
      if (idx < ENTRIES && tbl_used[idx]) begin
        case (c.cmd)
          CMD_FREE: begin
            if (!tbl_locked[idx] && tbl_owner[idx] == 8'd0) begin
              tbl_used[idx] = 1'b0;
              tbl_locked[idx] = 1'b0;
              tbl_ident[idx] = '0;
              tbl_owner[idx] = '0;
              r.status = ST_OK;
            end
          end
          CMD_LOCK: begin
            if (tbl_locked[idx]) begin
              r.status = ST_BUSY;
              busy_hits++;
            end else begin
              tbl_locked[idx] = 1'b1;
              tbl_owner[idx] = c.requester;
              r.status = ST_OK;
            end
          end
          default: begin
            if (tbl_locked[idx] && tbl_owner[idx] == c.requester) begin
              tbl_locked[idx] = 1'b0;
              tbl_owner[idx] = '0;
              r.status = ST_OK;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  // Mostly commands aimed at live entries, with some noise on the identifier.
  function automatic mte_in_t pick_command(int alloc_pct);
    mte_in_t c;
    int live[$];
    int k;
    int roll;
    c.requester = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    c.mutex_ident = 16'($urandom());
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_used[i]) live.push_back(i);
    end
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      c.cmd = CMD_ALLOC;
    end else begin
      c.cmd = 2'($urandom_range(1, 3));
      roll = $urandom_range(0, 99);
      if (live.size() > 0 && roll < 80) begin
        k = live[$urandom_range(0, live.size() - 1)];
        c.mutex_ident = tbl_ident[k];
        if (tbl_locked[k] && $urandom_range(0, 99) < 60) c.requester = tbl_owner[k];
      end else if (roll < 88) begin
        c.mutex_ident = 16'd0;
      end else if (roll < 92) begin
        c.mutex_ident = 16'hFFFF;
      end
    end
    return c;
  endfunction

  // Drives one request and records its expected response once the transfer happens.
  task automatic send_cmd(input mte_in_t c, input logic typed, input mte_out_t typed_rsp,
                          output mte_out_t got);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req <= c;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    got = apply_command(c);
    expected_rsp.push_back(typed ? typed_rsp : got);
    cmds_sent++;
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 99) < 30);
      2: rsp_stall <= ($urandom_range(0, 99) < 70);
      default: rsp_stall <= (stall_tick % 5) < 2;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_seen++;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        $display("%0t: response transfer with none expected: status %0d new_ident %0d",
                 $time, rsp.status, rsp.new_ident);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
        end
        if (rsp.new_ident !== want.new_ident) begin
          mismatches++;
          $display("%0t: new_ident expected %0d got %0d", $time, want.new_ident,
                   rsp.new_ident);
        end
      end
    end
  end

  initial begin
    #400_000_000;
    $display("tb_mutex_table_engine: done, errors");
    $finish;
  end

  initial begin
    mte_out_t r;
    int alloc_pct;

    clear_table();
    // Opening checks from an empty table; typed rows carry their expected responses.
    directed_rows.push_back(row(CMD_ALLOC,  16'hFFFF, 8'd255, 1'b1, ST_OK,   16'd1));
    directed_rows.push_back(row(CMD_FREE,   16'd0,    8'd1,   1'b1, ST_FAIL, 16'd0));
    directed_rows.push_back(row(CMD_LOCK,   16'd1,    8'd255, 1'b1, ST_OK,   16'd0));
    directed_rows.push_back(row(CMD_LOCK,   16'd1,    8'd255, 1'b1, ST_BUSY, 16'd0));
    directed_rows.push_back(row(CMD_LOCK,   16'd1,    8'd1,   1'b1, ST_BUSY, 16'd0));
    directed_rows.push_back(row(CMD_FREE,   16'd1,    8'd255, 1'b1, ST_FAIL, 16'd0));
    directed_rows.push_back(row(CMD_UNLOCK, 16'd1,    8'd1,   1'b1, ST_FAIL, 16'd0));
    directed_rows.push_back(row(CMD_UNLOCK, 16'd1,    8'd255, 1'b1, ST_OK,   16'd0));
    directed_rows.push_back(row(CMD_UNLOCK, 16'd1,    8'd255, 1'b1, ST_FAIL, 16'd0));
    directed_rows.push_back(row(CMD_LOCK,   16'hFFFF, 8'd3,   1'b1, ST_FAIL, 16'd0));
    directed_rows.push_back(row(CMD_UNLOCK, 16'd0,    8'd0,   1'b1, ST_FAIL, 16'd0));
    directed_rows.push_back(row(CMD_ALLOC,  16'd0,    8'd1,   1'b1, ST_OK,   16'd2));
    directed_rows.push_back(row(CMD_LOCK,   16'd2,    8'd0,   1'b1, ST_OK,   16'd0));
    directed_rows.push_back(row(CMD_UNLOCK, 16'd2,    8'd1,   1'b1, ST_FAIL, 16'd0));
    directed_rows.push_back(row(CMD_FREE,   16'd2,    8'd0,   1'b1, ST_FAIL, 16'd0));
    directed_rows.push_back(row(CMD_UNLOCK, 16'd2,    8'd0,   1'b1, ST_OK,   16'd0));
    directed_rows.push_back(row(CMD_FREE,   16'd2,    8'd0,   1'b1, ST_OK,   16'd0));
    directed_rows.push_back(row(CMD_FREE,   16'd1,    8'd128, 1'b1, ST_OK,   16'd0));
    directed_rows.push_back(row(CMD_FREE,   16'd1,    8'd128, 1'b1, ST_FAIL, 16'd0));
    directed_rows.push_back(row(CMD_ALLOC,  16'h5555, 8'hAA,  1'b0, ST_OK,   16'd0));
    directed_rows.push_back(row(CMD_LOCK,   16'd3,    8'hAA,  1'b0, ST_OK,   16'd0));
    directed_rows.push_back(row(CMD_UNLOCK, 16'd3,    8'hAA,  1'b0, ST_OK,   16'd0));
    directed_rows.push_back(row(CMD_FREE,   16'd3,    8'h55,  1'b0, ST_OK,   16'd0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].rsp, r);

    // Alternate fill-heavy and drain-heavy phases so the table runs full and empty.
    for (int p = 0; p < 4; p++) begin
      alloc_pct = (p == 0) ? 55 : (p == 1) ? 15 : (p == 2) ? 45 : 20;
      repeat (413) send_cmd(pick_command(alloc_pct), 1'b0, '0, r);
    end
    req_valid <= 1'b0;

    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d commands, checked %0d responses, %0d mismatches.",
             cmds_sent, rsp_seen, mismatches);
    $display("Table full %0d times, busy %0d times, identifier counter wrapped %0d times.",
             full_hits, busy_hits, ctr_wraps);
    if (mismatches == 0) begin
      $display("tb_mutex_table_engine: done, clean");
    end else begin
      $display("tb_mutex_table_engine: done, errors");
    end
    $finish;
  end

endmodule
